/* sv/fractional_step_sequencer_macros.svh */
// assertion helpers, expect clk and rst_n in scope
`ifndef FRACTIONAL_STEP_SEQUENCER_MACROS_SVH
`define FRACTIONAL_STEP_SEQUENCER_MACROS_SVH

// same-cycle implication
`define FSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define FSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/fss_pkg.sv */
`default_nettype none

package fss_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int STAGE_BITS = 16;
  localparam int DUR_W      = 32;
  localparam int WHOLE_W    = DUR_W - FRAC_BITS;
  localparam int TICK_W     = WHOLE_W + 1;
  localparam int STAGE_W    = STAGE_BITS + 1;
  localparam int EXT_W      = STAGE_BITS + 2;

  typedef struct packed {
    logic signed [DUR_W-1:0]      duration;
    logic signed [STAGE_BITS-1:0] start_stage;
    logic signed [STAGE_BITS-1:0] end_stage;
    logic                         clear;
  } item_t;

  typedef struct packed {
    logic signed [STAGE_W-1:0] stage;
    logic                      sync;
    logic                      cycle;
    logic [DUR_W-1:0]          current_duration;
  } result_t;

endpackage

`default_nettype wire

/* sv/fss_in_stage.sv */
`default_nettype none

module fss_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire fss_pkg::item_t in_item,
  input  wire logic          adv_i,
  output logic               valid_o,
  output fss_pkg::item_t     item_o
);

  logic           valid_r, valid_nxt;
  fss_pkg::item_t item_r;
  logic           take;

  assign in_stall = valid_r && !adv_i;
  assign take     = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (adv_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r <= in_item;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

`default_nettype wire

/* sv/fss_core.sv */
`default_nettype none
`include "fractional_step_sequencer_macros.svh"

module fss_core (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           fire_i,
  input  wire fss_pkg::item_t item_i,
  output fss_pkg::result_t    res_o
);

  logic        [fss_pkg::TICK_W-1:0]     tick_r, tick_nxt;
  logic        [fss_pkg::WHOLE_W-1:0]    whole_r, whole_nxt;
  logic signed [fss_pkg::STAGE_W-1:0]    stage_r, stage_nxt;
  logic        [fss_pkg::FRAC_BITS-1:0]  accum_r, accum_nxt;
  logic        [fss_pkg::FRAC_BITS-1:0]  step_r, step_nxt;
  logic        [fss_pkg::DUR_W-1:0]      last_r, last_nxt;
  logic                                  pend_r, pend_nxt;
  logic        [fss_pkg::DUR_W-1:0]      hold_r, hold_nxt;

  logic        [fss_pkg::DUR_W-1:0]      dur;
  logic        [fss_pkg::DUR_W-1:0]      mag;
  logic signed [fss_pkg::EXT_W-1:0]      start_ext, end_ext, cur_ext, moved;
  logic                                  down, wrap;
  logic        [fss_pkg::FRAC_BITS:0]    acc_sum;
  logic                                  sync, cycle;
  logic                                  clr_fire;
  logic        [fss_pkg::TICK_W-1:0]     tick_lim;
  logic                                  tick_low;

  assign dur = item_i.duration;
  assign mag = dur[fss_pkg::DUR_W-1] ? (~dur + fss_pkg::DUR_W'(1)) : dur;

  assign start_ext = {{2{item_i.start_stage[fss_pkg::STAGE_BITS-1]}}, item_i.start_stage};
  assign end_ext   = {{2{item_i.end_stage[fss_pkg::STAGE_BITS-1]}}, item_i.end_stage};
  assign down      = $signed(item_i.start_stage) > $signed(item_i.end_stage);

  always_comb begin
    tick_nxt  = tick_r;
    whole_nxt = whole_r;
    stage_nxt = stage_r;
    accum_nxt = accum_r;
    step_nxt  = step_r;
    last_nxt  = last_r;
    pend_nxt  = pend_r;
    hold_nxt  = hold_r;
    sync      = 1'b0;
    cycle     = 1'b0;
    cur_ext   = '0;
    moved     = '0;
    wrap      = 1'b0;
    acc_sum   = '0;

    if (item_i.clear) begin
      tick_nxt  = fss_pkg::TICK_W'(1);
      whole_nxt = '0;
      accum_nxt = '0;
      step_nxt  = '0;
      last_nxt  = '0;
      stage_nxt = start_ext[fss_pkg::STAGE_W-1:0];
      pend_nxt  = 1'b1;
    end

    // first tick after reset or clear takes the duration up at once
    if (pend_nxt) begin
      pend_nxt = 1'b0;
      sync     = 1'b1;
      hold_nxt = mag;
      if (dur != last_nxt) begin
        last_nxt  = dur;
        whole_nxt = mag[fss_pkg::DUR_W-1 -: fss_pkg::WHOLE_W];
        step_nxt  = mag[fss_pkg::FRAC_BITS-1:0];
        accum_nxt = mag[fss_pkg::FRAC_BITS-1:0];
      end
    end

    if (tick_nxt > {1'b0, whole_nxt}) begin
      tick_nxt = fss_pkg::TICK_W'(1);
      acc_sum  = {1'b0, accum_nxt} + {1'b0, step_nxt};
      // fraction overflow stretches the next stage by one tick
      if (acc_sum[fss_pkg::FRAC_BITS]) begin
        tick_nxt = '0;
      end
      accum_nxt = acc_sum[fss_pkg::FRAC_BITS-1:0];
      cur_ext   = {stage_nxt[fss_pkg::STAGE_W-1], stage_nxt};
      moved     = down ? (cur_ext - fss_pkg::EXT_W'(1)) : (cur_ext + fss_pkg::EXT_W'(1));
      wrap      = (!down && (moved >= end_ext)) || (down && (moved <= end_ext));
      if (wrap) begin
        stage_nxt = start_ext[fss_pkg::STAGE_W-1:0];
        cycle     = 1'b1;
      end else begin
        stage_nxt = moved[fss_pkg::STAGE_W-1:0];
      end
      sync     = 1'b1;
      hold_nxt = mag;
      if (dur != last_nxt) begin
        last_nxt  = dur;
        whole_nxt = mag[fss_pkg::DUR_W-1 -: fss_pkg::WHOLE_W];
        step_nxt  = mag[fss_pkg::FRAC_BITS-1:0];
        accum_nxt = mag[fss_pkg::FRAC_BITS-1:0];
      end
    end

    tick_nxt = tick_nxt + fss_pkg::TICK_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r  <= fss_pkg::TICK_W'(1);
      whole_r <= '0;
      stage_r <= '0;
      accum_r <= '0;
      step_r  <= '0;
      last_r  <= '0;
      pend_r  <= 1'b1;
      hold_r  <= '0;
    end else if (fire_i) begin
      tick_r  <= tick_nxt;
      whole_r <= whole_nxt;
      stage_r <= stage_nxt;
      accum_r <= accum_nxt;
      step_r  <= step_nxt;
      last_r  <= last_nxt;
      pend_r  <= pend_nxt;
      hold_r  <= hold_nxt;
    end
  end

  assign res_o.stage            = stage_nxt;
  assign res_o.sync             = sync;
  assign res_o.cycle            = cycle;
  assign res_o.current_duration = hold_nxt;

  assign clr_fire = fire_i && item_i.clear;
  assign tick_lim = {1'b0, whole_r} + fss_pkg::TICK_W'(2);
  assign tick_low = (tick_r == fss_pkg::TICK_W'(1)) || (tick_r == fss_pkg::TICK_W'(2));

  `FSS_ASSERT_NOW(a_wrap_has_sync, fire_i && res_o.cycle, res_o.sync, "wrap without sync")
  `FSS_ASSERT_NOW(a_tick_bounded, 1'b1, tick_r <= tick_lim, "tick count ran past period")
  `FSS_ASSERT_NXT(a_clear_restart, clr_fire, !pend_r && tick_low, "clear did not restart count")

endmodule

`default_nettype wire

/* sv/fss_out_stage.sv */
`default_nettype none

module fss_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             valid_i,
  input  wire fss_pkg::result_t res_i,
  output logic                  adv_o,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output fss_pkg::result_t      res_o
);

  logic             valid_r, valid_nxt;
  fss_pkg::result_t res_r;

  // register free when empty or its word leaves this edge
  assign adv_o = valid_i && (!valid_r || !out_stall);

  always_comb begin
    valid_nxt = valid_r;
    if (adv_o) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      res_r <= res_i;
    end
  end

  assign out_valid = valid_r;
  assign res_o     = res_r;

endmodule

`default_nettype wire

/* sv/fractional_step_sequencer.sv */
// channel   direction  handshake            word
// in_       input      in_valid/in_stall    duration, start_stage, end_stage, clear
// out_      output     out_valid/out_stall  stage, sync, cycle, current_duration
//
// one word in per cycle while out_stall is low, one result per word
// stage arithmetic is one compare, add and wrap pass between input and result registers
// rst_n is synchronous, active low; state returns to tick count 1, reload pending
// out_stall holds the result register; in_stall rises only while both registers are full
`default_nettype none

module fractional_step_sequencer (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [fss_pkg::DUR_W-1:0]      in_duration,
  input  wire logic signed [fss_pkg::STAGE_BITS-1:0] in_start_stage,
  input  wire logic signed [fss_pkg::STAGE_BITS-1:0] in_end_stage,
  input  wire logic                                  in_clear,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [fss_pkg::STAGE_W-1:0]         out_stage,
  output logic                                       out_sync,
  output logic                                       out_cycle,
  output logic [fss_pkg::DUR_W-1:0]                  out_current_duration
);

  fss_pkg::item_t   in_item, s1_item;
  fss_pkg::result_t core_res, out_res;
  logic             s1_valid, adv;

  assign in_item.duration    = in_duration;
  assign in_item.start_stage = in_start_stage;
  assign in_item.end_stage   = in_end_stage;
  assign in_item.clear       = in_clear;

  fss_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv_i    (adv),
    .valid_o  (s1_valid),
    .item_o   (s1_item)
  );

  fss_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire_i (adv),
    .item_i (s1_item),
    .res_o  (core_res)
  );

  fss_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_i   (s1_valid),
    .res_i     (core_res),
    .adv_o     (adv),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res_o     (out_res)
  );

  assign out_stage            = out_res.stage;
  assign out_sync             = out_res.sync;
  assign out_cycle            = out_res.cycle;
  assign out_current_duration = out_res.current_duration;

endmodule

`default_nettype wire
